// ===== hw/rtl/fbld_pkg.sv =====
// Shared types and constants of the frame buffer line drawer.
// Depends on nothing; used by the top level by scoped names.
package fbld_pkg;

   localparam int unsigned COORD_W = 11;
   localparam int unsigned DIFF_W  = COORD_W + 1;
   localparam int unsigned ERR_W   = COORD_W + 3;

   typedef enum logic [1:0] {
      CMD_LINE  = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_BYTE  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LINE  = 4'b0010,
      ST_CLEAR = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

// ===== hw/rtl/fbld_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Read returns the contents before a write at the same edge. No dependencies.
module fbld_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/framebuffer_line_drawer.sv =====
// Top level: monochrome frame store with Bresenham line drawing, clearing and readback.
// Depends on fbld_pkg (types, widths) and fbld_ram (frame store memory).
//
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid / req_ready | cmd, x/y start, x/y end, page, column
//  rsp_    | out       | rsp_valid / rsp_ready | pixel_value, page_byte
//
// A line visits its points in order and merges each on-screen pixel into its store
// byte by a read-modify-write on the single frame store port pair; a clear zeroes
// one store entry per cycle.
// After reset a clearing pass over every store entry runs before the first item.
// A result waiting on rsp_ready holds the finish of the next item, not its accept.
module framebuffer_line_drawer #(
   parameter int unsigned COLUMNS = 128,
   parameter int unsigned PAGES   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic signed [10:0] req_x_start,
   input  logic signed [10:0] req_y_start,
   input  logic signed [10:0] req_x_end,
   input  logic signed [10:0] req_y_end,
   input  logic [2:0]  req_page_sel,
   input  logic [6:0]  req_column_sel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_pixel_value,
   output logic [7:0]  rsp_page_byte
);

   localparam int unsigned DEPTH    = PAGES * COLUMNS;
   localparam int unsigned ADDR_W   = $clog2(DEPTH);
   localparam int unsigned SCREEN_H = PAGES * 8;
   localparam int unsigned CW       = fbld_pkg::COORD_W;
   localparam int unsigned DW       = fbld_pkg::DIFF_W;
   localparam int unsigned EW       = fbld_pkg::ERR_W;

   fbld_pkg::state_type state_ff, state_in;
   fbld_pkg::cmd_type   cmd_ff, cmd_in;
   logic                boot_ff, boot_in;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, xe_ff, xe_in, ye_ff, ye_in;
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic                 sx_ff, sx_in, sy_ff, sy_in;

   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              ok_ff, ok_in;
   logic [2:0]        bit_ff, bit_in;

   logic              b_valid_ff, b_valid_in;
   logic [ADDR_W-1:0] b_addr_ff, b_addr_in;
   logic [2:0]        b_bit_ff, b_bit_in;
   logic              wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0] wb_addr_ff, wb_addr_in;
   logic [7:0]        wb_data_ff, wb_data_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_pix_ff, rsp_pix_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;

   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]        ram_wr_data, ram_rd_data;

   logic                 accept, out_free;
   logic                 cur_on, req_on, byte_ok;
   logic [ADDR_W-1:0]    cur_addr, req_pix_addr, req_byte_addr;
   logic signed [DW-1:0] diff_x, diff_y;
   logic signed [EW:0]   e2;
   logic                 step_x, step_y;
   logic [7:0]           merge_base, merged;

   fbld_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == fbld_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cur_on = !x_ff[CW-1] && (x_ff[CW-2:0] < (CW-1)'(COLUMNS))
                && !y_ff[CW-1] && (y_ff[CW-2:0] < (CW-1)'(SCREEN_H));
   assign cur_addr = ADDR_W'(ADDR_W'(y_ff[CW-2:3]) * ADDR_W'(COLUMNS) + ADDR_W'(x_ff[CW-2:0]));

   assign req_on = !req_x_start[CW-1] && (req_x_start[CW-2:0] < (CW-1)'(COLUMNS))
                && !req_y_start[CW-1] && (req_y_start[CW-2:0] < (CW-1)'(SCREEN_H));
   assign req_pix_addr = ADDR_W'(ADDR_W'(req_y_start[CW-2:3]) * ADDR_W'(COLUMNS)
                       + ADDR_W'(req_x_start[CW-2:0]));
   assign byte_ok = (5'(req_page_sel) < 5'(PAGES)) && (9'(req_column_sel) < 9'(COLUMNS));
   assign req_byte_addr = ADDR_W'(ADDR_W'(req_page_sel) * ADDR_W'(COLUMNS)
                        + ADDR_W'(req_column_sel));

   assign diff_x = DW'(req_x_end) - DW'(req_x_start);
   assign diff_y = DW'(req_y_end) - DW'(req_y_start);

   assign e2     = {err_ff, 1'b0};
   assign step_x = (e2 >= (EW+1)'(dy_ff));
   assign step_y = (e2 <= (EW+1)'(dx_ff));

   assign merge_base = (wb_valid_ff && (wb_addr_ff == b_addr_ff)) ? wb_data_ff : ram_rd_data;
   assign merged     = merge_base | (8'd1 << b_bit_ff);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      boot_in     = boot_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      xe_in       = xe_ff;
      ye_in       = ye_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      err_in      = err_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      clr_in      = clr_ff;
      ok_in       = ok_ff;
      bit_in      = bit_ff;
      b_valid_in  = 1'b0;
      b_addr_in   = b_addr_ff;
      b_bit_in    = b_bit_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cur_addr;
      ram_wr_en   = 1'b0;
      ram_wr_addr = b_addr_ff;
      ram_wr_data = merged;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_byte_in  = rsp_byte_ff;

      // stage B: merge the pixel into the fetched byte and write back
      if (b_valid_ff) begin
         ram_wr_en = 1'b1;
      end
      wb_valid_in = b_valid_ff;
      wb_addr_in  = b_addr_ff;
      wb_data_in  = merged;

      unique case (state_ff)
         fbld_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in = fbld_pkg::cmd_type'(req_cmd);
               unique case (fbld_pkg::cmd_type'(req_cmd))
                  fbld_pkg::CMD_LINE: begin
                     x_in   = req_x_start;
                     y_in   = req_y_start;
                     xe_in  = req_x_end;
                     ye_in  = req_y_end;
                     dx_in  = diff_x[DW-1] ? -diff_x : diff_x;
                     dy_in  = diff_y[DW-1] ? diff_y : -diff_y;
                     sx_in  = !(req_x_start < req_x_end);
                     sy_in  = !(req_y_start < req_y_end);
                     err_in = EW'(diff_x[DW-1] ? -diff_x : diff_x)
                            + EW'(diff_y[DW-1] ? diff_y : -diff_y);
                     state_in = fbld_pkg::ST_LINE;
                  end
                  fbld_pkg::CMD_PIXEL: begin
                     ok_in       = req_on;
                     bit_in      = req_y_start[2:0];
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = req_pix_addr;
                     state_in    = fbld_pkg::ST_DONE;
                  end
                  fbld_pkg::CMD_BYTE: begin
                     ok_in       = byte_ok;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = req_byte_addr;
                     state_in    = fbld_pkg::ST_DONE;
                  end
                  fbld_pkg::CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = fbld_pkg::ST_CLEAR;
                  end
                  default: state_in = fbld_pkg::ST_IDLE;
               endcase
            end
         end
         fbld_pkg::ST_LINE: begin
            // stage A: fetch the byte under the current point
            ram_rd_en  = cur_on;
            b_valid_in = cur_on;
            b_addr_in  = cur_addr;
            b_bit_in   = y_ff[2:0];
            if ((x_ff == xe_ff) && (y_ff == ye_ff)) begin
               state_in = fbld_pkg::ST_DONE;
            end else begin
               err_in = err_ff + (step_x ? EW'(dy_ff) : EW'(0))
                               + (step_y ? EW'(dx_ff) : EW'(0));
               if (step_x) begin
                  x_in = sx_ff ? x_ff - CW'(1) : x_ff + CW'(1);
               end
               if (step_y) begin
                  y_in = sy_ff ? y_ff - CW'(1) : y_ff + CW'(1);
               end
            end
         end
         fbld_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? fbld_pkg::ST_IDLE : fbld_pkg::ST_DONE;
            end
         end
         fbld_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = (cmd_ff == fbld_pkg::CMD_PIXEL) && ok_ff && ram_rd_data[bit_ff];
               rsp_byte_in  = ((cmd_ff == fbld_pkg::CMD_BYTE) && ok_ff) ? ram_rd_data : 8'd0;
               state_in     = fbld_pkg::ST_IDLE;
            end
         end
         default: state_in = fbld_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbld_pkg::ST_CLEAR;
         boot_ff      <= 1'b1;
         clr_ff       <= '0;
         b_valid_ff   <= 1'b0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         clr_ff       <= clr_in;
         b_valid_ff   <= b_valid_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      xe_ff       <= xe_in;
      ye_ff       <= ye_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      err_ff      <= err_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      ok_ff       <= ok_in;
      bit_ff      <= bit_in;
      b_addr_ff   <= b_addr_in;
      b_bit_ff    <= b_bit_in;
      wb_addr_ff  <= wb_addr_in;
      wb_data_ff  <= wb_data_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pix_ff;
   assign rsp_page_byte   = rsp_byte_ff;

endmodule
